// ===== hdl/asfc_pkg.sv =====
// Shared types, character codes and helper functions of the ASCII sentence framer.
package asfc_pkg;

    // Characters that steer the framing.
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Input operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // Checksum digits after the star, and the saturation point of that count.
    localparam logic [3:0] HEX_DIGITS     = 4'd8;
    localparam logic [3:0] AFTER_STAR_SAT = 4'd9;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [2:0] {
        ST_SKIPPED   = 3'd0,
        ST_NEED_MORE = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_READY     = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_NOTHING   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CK_NONE    = 2'd0,
        CK_MISSING = 2'd1,
        CK_INVALID = 2'd2,
        CK_VALID   = 2'd3
    } t_check;

    typedef enum logic [1:0] {
        SY_HASH    = 2'd0,
        SY_DOLLAR  = 2'd1,
        SY_PERCENT = 2'd2
    } t_sync;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic [62:0] time_ns;
        logic        time_present;
    } t_item;

    typedef struct packed {
        t_status     status;
        t_sync       sync_kind;
        t_check      check_status;
        logic [31:0] reported_crc;
        logic [31:0] computed_crc;
        logic [62:0] frame_time_ns;
        logic        frame_time_present;
        logic [15:0] frame_bytes;
        logic [15:0] payload_bytes;
        logic [15:0] name_bytes;
    } t_result;

    // Reflected CRC-32 update by one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Bit 4 marks a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== hdl/ascii_sentence_framer_crc32.sv =====
// Top level of the ASCII sentence framer with CRC-32 checking.
//
// Usage: each input transaction on the s_axis channel carries one received byte with its
// arrival timestamp, or an end-of-stream event (tuser bit 0 set). Every input transaction
// produces exactly one result transaction on the m_axis channel. The status in m_axis_tuser
// tells whether the byte was skipped, opened or extended a frame, overflowed it, or closed it
// with a record; end of stream reports a truncated frame or that nothing was pending.
// The byte is captured in an input register when it is accepted, parsed in one pass
// against the frame state, and the result is written into the output register, where it
// is offered on m_axis.
// Throughput is one transaction per cycle while the receiver does not stall; the limit is
// the bytewise CRC-32 update and the length counters that feed the next byte.
// When the receiver stalls, the finished result stays in the output register and one more
// byte is held in the input register; only then does s_axis_tready drop.
// Reset (synchronous, active low) empties both registers, closes any open frame and sets
// the frame length limit to 1024 bytes. The limit is written through the APB port at
// address 0; the user must do so only while idle (not enforced); pready is always high.
module ascii_sentence_framer_crc32 #(
    parameter int LENGTH_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input channel.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // data_byte[7:0], time_ns[70:8], zero[71]
    input  logic [1:0]   s_axis_tuser,  // opcode[0], time_present[1]
    // Result channel.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sync_kind[1:0], check_status[3:2], reported_crc[35:4], computed_crc[67:36],
    // frame_time_ns[130:68], frame_time_present[131], frame_bytes[147:132],
    // payload_bytes[163:148], name_bytes[179:164], zero[183:180]
    output logic [183:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,  // status[2:0]
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic               r_in_valid;
    asfc_pkg::t_item    r_in;
    logic               r_out_valid;
    asfc_pkg::t_result  r_out;
    logic [15:0]        r_max_frame_bytes;

    logic               advance;
    logic               in_take;
    asfc_pkg::t_result  parse_result;

    // The parse stage moves whenever the output register is free or being emptied.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode       <= s_axis_tuser[0];
            r_in.data_byte    <= s_axis_tdata[7:0];
            r_in.time_ns      <= s_axis_tdata[70:8];
            r_in.time_present <= s_axis_tuser[1];
        end
    end

    asfc_frame_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_item            (r_in),
        .i_max_frame_bytes (r_max_frame_bytes),
        .o_result          (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= parse_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {4'd0, r_out.name_bytes, r_out.payload_bytes, r_out.frame_bytes,
                            r_out.frame_time_present, r_out.frame_time_ns,
                            r_out.computed_crc, r_out.reported_crc,
                            r_out.check_status, r_out.sync_kind};

    // Configuration register: only address bit 2 selects, so one register sits at 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_bytes <= 16'd1024;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_max_frame_bytes <= pwdata[15:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_max_frame_bytes};
    assign pready = 1'b1;

    // Only a finished record carries anything beyond its status.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != asfc_pkg::ST_READY) |-> (m_axis_tdata == '0))
        else $error("fields set on a result that is not a record");

    a_len_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == asfc_pkg::ST_READY) |->
        (r_out.payload_bytes <= r_out.frame_bytes && r_out.name_bytes <= r_out.payload_bytes))
        else $error("record lengths out of order");

    a_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.check_status == asfc_pkg::CK_VALID) |->
        (r_out.reported_crc == r_out.computed_crc))
        else $error("valid check with differing checksums");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> (r_in_valid && $stable(r_in)))
        else $error("held byte lost while the output stalls");

endmodule

// ===== hdl/asfc_frame_parse.sv =====
// Frame state registers and the single-pass per-byte parsing logic.
module asfc_frame_parse #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  asfc_pkg::t_item        i_item,
    input  logic [15:0]            i_max_frame_bytes,
    output asfc_pkg::t_result      o_result
);

    localparam int LW = LENGTH_BITS;
    localparam int CW = (LW > 16) ? LW : 16;
    localparam logic [LW-1:0] LEN_MAX = '1;

    function automatic logic [LW-1:0] sat_inc(input logic [LW-1:0] v);
        return (v == LEN_MAX) ? v : v + LW'(1);
    endfunction

    logic              r_in_frame,   n_in_frame;
    asfc_pkg::t_sync   r_sync_code,  n_sync_code;
    logic [LW-1:0]     r_byte_count, n_byte_count;
    logic [62:0]       r_latched_time, n_latched_time;
    logic              r_latched_present, n_latched_present;
    logic [31:0]       r_running_crc, n_running_crc;
    logic [31:0]       r_crc_at_star, n_crc_at_star;
    logic              r_star_seen,  n_star_seen;
    logic [3:0]        r_after_star, n_after_star;
    logic [31:0]       r_hex_accum,  n_hex_accum;
    logic              r_hex_good,   n_hex_good;
    logic [LW-1:0]     r_pending_cr, n_pending_cr;
    logic [LW-1:0]     r_name_count, n_name_count;
    logic              r_name_closed, n_name_closed;

    logic [7:0]        b;
    logic [CW-1:0]     lim_cfg, lim_max, limit;
    logic              overflow;
    logic [LW-1:0]     bc_inc;
    logic [LW:0]       cr_sum;
    logic [3:0]        cr_merge;
    logic [4:0]        hv;
    logic [3:0]        asc;
    logic              hg;
    logic [LW:0]       trimmed, bc_wide, payload, name_w;
    logic              clear;
    asfc_pkg::t_result res;

    assign b        = i_item.data_byte;
    assign lim_cfg  = CW'(i_max_frame_bytes);
    assign lim_max  = CW'(LEN_MAX);
    assign limit    = (lim_cfg < lim_max) ? lim_cfg : lim_max;
    assign overflow = CW'(r_byte_count) >= limit;
    assign bc_inc   = sat_inc(r_byte_count);
    assign cr_sum   = {1'b0, r_pending_cr} + (LW+1)'(r_after_star);
    assign cr_merge = (cr_sum > (LW+1)'(asfc_pkg::AFTER_STAR_SAT)) ?
                      asfc_pkg::AFTER_STAR_SAT : cr_sum[3:0];
    assign hv       = asfc_pkg::hex_value(b);
    assign trimmed  = {1'b0, r_pending_cr} + (LW+1)'(2);
    assign bc_wide  = {1'b0, bc_inc};
    assign payload  = (bc_wide > trimmed) ? bc_wide - trimmed : '0;
    assign name_w   = ((LW+1)'(r_name_count) < payload) ? (LW+1)'(r_name_count) : payload;

    always_comb begin
        n_in_frame        = r_in_frame;
        n_sync_code       = r_sync_code;
        n_byte_count      = r_byte_count;
        n_latched_time    = r_latched_time;
        n_latched_present = r_latched_present;
        n_running_crc     = r_running_crc;
        n_crc_at_star     = r_crc_at_star;
        n_star_seen       = r_star_seen;
        n_after_star      = r_after_star;
        n_hex_accum       = r_hex_accum;
        n_hex_good        = r_hex_good;
        n_pending_cr      = r_pending_cr;
        n_name_count      = r_name_count;
        n_name_closed     = r_name_closed;
        asc               = r_after_star;
        hg                = r_hex_good;
        clear             = 1'b0;
        res               = '0;
        res.status        = asfc_pkg::ST_SKIPPED;

        if (i_item.opcode == asfc_pkg::OP_EOS) begin
            res.status = r_in_frame ? asfc_pkg::ST_TRUNCATED : asfc_pkg::ST_NOTHING;
            clear      = 1'b1;
        end else if (!r_in_frame) begin
            // Outside a frame every register already holds its cleared value.
            if (b == asfc_pkg::CH_HASH || b == asfc_pkg::CH_DOLLAR ||
                b == asfc_pkg::CH_PERCENT) begin
                n_in_frame        = 1'b1;
                n_sync_code       = (b == asfc_pkg::CH_HASH)   ? asfc_pkg::SY_HASH :
                                    (b == asfc_pkg::CH_DOLLAR) ? asfc_pkg::SY_DOLLAR :
                                                                 asfc_pkg::SY_PERCENT;
                n_byte_count      = LW'(1);
                n_latched_time    = i_item.time_ns;
                n_latched_present = i_item.time_present;
                res.status        = asfc_pkg::ST_NEED_MORE;
            end
        end else if (overflow) begin
            res.status = asfc_pkg::ST_OVERFLOW;
            clear      = 1'b1;
        end else begin
            n_byte_count = bc_inc;
            if (b != asfc_pkg::CH_LF) begin
                res.status = asfc_pkg::ST_NEED_MORE;
                if (b == asfc_pkg::CH_CR) begin
                    n_pending_cr = sat_inc(r_pending_cr);
                end else begin
                    // Carriage returns after the star spoil the checksum digits.
                    if (r_pending_cr != '0 && r_star_seen) begin
                        asc = cr_merge;
                        hg  = 1'b0;
                    end
                    n_pending_cr = '0;
                    if (b == asfc_pkg::CH_STAR) begin
                        n_star_seen   = 1'b1;
                        n_crc_at_star = r_running_crc;
                        asc           = '0;
                        n_hex_accum   = '0;
                        hg            = 1'b1;
                    end else if (r_star_seen) begin
                        if (asc < asfc_pkg::AFTER_STAR_SAT) begin
                            asc = asc + 4'd1;
                        end
                        if (!hv[4]) begin
                            hg = 1'b0;
                        end else if (asc <= asfc_pkg::HEX_DIGITS) begin
                            n_hex_accum = {r_hex_accum[27:0], hv[3:0]};
                        end
                    end
                    n_after_star = asc;
                    n_hex_good   = hg;
                end
                if (!r_name_closed) begin
                    if (b == asfc_pkg::CH_COMMA || b == asfc_pkg::CH_SEMI ||
                        b == asfc_pkg::CH_STAR  || b == asfc_pkg::CH_SPACE) begin
                        n_name_closed = 1'b1;
                    end else begin
                        n_name_count = sat_inc(r_name_count);
                    end
                end
                n_running_crc = asfc_pkg::crc_byte(r_running_crc, b);
            end else begin
                res.status             = asfc_pkg::ST_READY;
                res.sync_kind          = r_sync_code;
                res.frame_time_ns      = r_latched_time;
                res.frame_time_present = r_latched_present;
                res.frame_bytes        = 16'(bc_inc);
                res.payload_bytes      = 16'(payload);
                res.name_bytes         = 16'(name_w);
                if (r_sync_code == asfc_pkg::SY_HASH) begin
                    if (!r_star_seen) begin
                        res.check_status = asfc_pkg::CK_MISSING;
                    end else if (r_after_star == asfc_pkg::HEX_DIGITS && r_hex_good) begin
                        res.reported_crc = r_hex_accum;
                        res.computed_crc = r_crc_at_star;
                        res.check_status = (r_hex_accum == r_crc_at_star) ?
                                           asfc_pkg::CK_VALID : asfc_pkg::CK_INVALID;
                    end else begin
                        res.check_status = asfc_pkg::CK_INVALID;
                    end
                end
                clear = 1'b1;
            end
        end

        if (clear) begin
            n_in_frame        = 1'b0;
            n_sync_code       = asfc_pkg::SY_HASH;
            n_byte_count      = '0;
            n_latched_time    = '0;
            n_latched_present = 1'b0;
            n_running_crc     = '0;
            n_crc_at_star     = '0;
            n_star_seen       = 1'b0;
            n_after_star      = '0;
            n_hex_accum       = '0;
            n_hex_good        = 1'b1;
            n_pending_cr      = '0;
            n_name_count      = '0;
            n_name_closed     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame        <= 1'b0;
            r_sync_code       <= asfc_pkg::SY_HASH;
            r_byte_count      <= '0;
            r_latched_time    <= '0;
            r_latched_present <= 1'b0;
            r_running_crc     <= '0;
            r_crc_at_star     <= '0;
            r_star_seen       <= 1'b0;
            r_after_star      <= '0;
            r_hex_accum       <= '0;
            r_hex_good        <= 1'b1;
            r_pending_cr      <= '0;
            r_name_count      <= '0;
            r_name_closed     <= 1'b0;
        end else if (i_advance) begin
            r_in_frame        <= n_in_frame;
            r_sync_code       <= n_sync_code;
            r_byte_count      <= n_byte_count;
            r_latched_time    <= n_latched_time;
            r_latched_present <= n_latched_present;
            r_running_crc     <= n_running_crc;
            r_crc_at_star     <= n_crc_at_star;
            r_star_seen       <= n_star_seen;
            r_after_star      <= n_after_star;
            r_hex_accum       <= n_hex_accum;
            r_hex_good        <= n_hex_good;
            r_pending_cr      <= n_pending_cr;
            r_name_count      <= n_name_count;
            r_name_closed     <= n_name_closed;
        end
    end

    assign o_result = res;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the ASCII sentence framer: directed and random bytes vs a predictor.
module testbench;

    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          COUNT_MAX      = 65535;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [2:0]  REG_MAX_FRAME  = 3'd0;
    localparam logic [15:0] LIMIT_AT_RESET = 16'd1024;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata  = '0;  // data_byte[7:0], time_ns[70:8], zero[71]
    logic [1:0]   s_axis_tuser  = '0;  // opcode[0], time_present[1]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // sync_kind[1:0], check_status[3:2], reported_crc[35:4], computed_crc[67:36],
    // frame_time_ns[130:68], frame_time_present[131], frame_bytes[147:132],
    // payload_bytes[163:148], name_bytes[179:164], zero[183:180]
    logic [183:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;    // status[2:0]
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [2:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    ascii_sentence_framer_crc32 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Byte transactions waiting for the driver, and the frame reports they are predicted to give.
    asfc_pkg::t_item   pending_items[$];
    asfc_pkg::t_result expected_reports[$];
    int                mismatches  = 0;
    int                cycle_count = 0;
    logic              quiet       = 1'b0;  // no idling on either side once set

    // Predictor copy of the framer: the frame length limit and the state of the open frame.
    logic [15:0]     frame_limit = LIMIT_AT_RESET;
    logic            fr_open;
    asfc_pkg::t_sync fr_sync;
    int              fr_count;
    logic [62:0]     fr_time;
    logic            fr_time_seen;
    logic [31:0]     crc_run;
    logic [31:0]     crc_star;
    logic            star_hit;
    int              star_tail;
    logic [31:0]     hex_acc;
    logic            hex_ok;
    int              cr_run;
    int              name_len;
    logic            name_done;

    // Reflected CRC-32, one data bit per step folded in before the shift.
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] x;
        x = c;
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ ((x[0] ^ d[i]) ? asfc_pkg::CRC_POLY : 32'd0);
        end
        return x;
    endfunction

    // Bit 4 set for a hex digit; letters of either case have a low nibble of 1 to 6.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic int count_up(input int v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    task automatic close_frame();
        fr_open      = 1'b0;
        fr_sync      = asfc_pkg::SY_HASH;
        fr_count     = 0;
        fr_time      = '0;
        fr_time_seen = 1'b0;
        crc_run      = '0;
        crc_star     = '0;
        star_hit     = 1'b0;
        star_tail    = 0;
        hex_acc      = '0;
        hex_ok       = 1'b1;
        cr_run       = 0;
        name_len     = 0;
        name_done    = 1'b0;
    endtask

    // One byte inside an open frame, line feed excepted.
    task automatic absorb_byte(input logic [7:0] b);
        logic [4:0] digit;
        if (b == asfc_pkg::CH_CR) begin
            // Carriage returns are held back until it is known whether they trail the line.
            cr_run = count_up(cr_run);
        end else begin
            if (cr_run != 0 && star_hit) begin
                // A carriage return inside the checksum spoils it.
                star_tail = (star_tail + cr_run > int'(asfc_pkg::AFTER_STAR_SAT)) ?
                            int'(asfc_pkg::AFTER_STAR_SAT) : star_tail + cr_run;
                hex_ok = 1'b0;
            end
            cr_run = 0;
            if (b == asfc_pkg::CH_STAR) begin
                // Only the last star counts: restart the checksum capture.
                star_hit  = 1'b1;
                crc_star  = crc_run;
                star_tail = 0;
                hex_acc   = '0;
                hex_ok    = 1'b1;
            end else if (star_hit) begin
                digit = hex_digit(b);
                if (star_tail < int'(asfc_pkg::AFTER_STAR_SAT)) begin
                    star_tail++;
                end
                if (!digit[4]) begin
                    hex_ok = 1'b0;
                end else if (star_tail <= int'(asfc_pkg::HEX_DIGITS)) begin
                    hex_acc = {hex_acc[27:0], digit[3:0]};
                end
            end
        end
        if (!name_done) begin
            if (b == asfc_pkg::CH_COMMA || b == asfc_pkg::CH_SEMI ||
                b == asfc_pkg::CH_STAR  || b == asfc_pkg::CH_SPACE) begin
                name_done = 1'b1;
            end else begin
                name_len = count_up(name_len);
            end
        end
        crc_run = crc32_step(crc_run, b);
    endtask

    // Works out the report that one accepted byte or end-of-stream transaction produces.
    task automatic parse_sentence_byte(input asfc_pkg::t_item it,
                                       output asfc_pkg::t_result rec);
        int limit;
        int trimmed;
        int payload;
        rec   = '0;
        limit = (int'(frame_limit) < COUNT_MAX) ? int'(frame_limit) : COUNT_MAX;
        if (it.opcode == asfc_pkg::OP_EOS) begin
            rec.status = fr_open ? asfc_pkg::ST_TRUNCATED : asfc_pkg::ST_NOTHING;
            close_frame();
        end else if (!fr_open) begin
            case (it.data_byte) inside
                asfc_pkg::CH_HASH, asfc_pkg::CH_DOLLAR, asfc_pkg::CH_PERCENT: begin
                    close_frame();
                    fr_open      = 1'b1;
                    fr_sync      = (it.data_byte == asfc_pkg::CH_HASH)   ? asfc_pkg::SY_HASH :
                                   (it.data_byte == asfc_pkg::CH_DOLLAR) ? asfc_pkg::SY_DOLLAR :
                                                                           asfc_pkg::SY_PERCENT;
                    fr_count     = 1;
                    fr_time      = it.time_ns;
                    fr_time_seen = it.time_present;
                    rec.status   = asfc_pkg::ST_NEED_MORE;
                end
                default: begin
                    rec.status = asfc_pkg::ST_SKIPPED;
                end
            endcase
        end else if (fr_count >= limit) begin
            // A limit of zero behaves like one: the byte after the sync overflows.
            close_frame();
            rec.status = asfc_pkg::ST_OVERFLOW;
        end else begin
            fr_count = count_up(fr_count);
            if (it.data_byte != asfc_pkg::CH_LF) begin
                absorb_byte(it.data_byte);
                rec.status = asfc_pkg::ST_NEED_MORE;
            end else begin
                // The sync, the line feed and any held carriage returns are not payload.
                trimmed = cr_run + 2;
                payload = (fr_count > trimmed) ? fr_count - trimmed : 0;
                rec.status    = asfc_pkg::ST_READY;
                rec.sync_kind = fr_sync;
                if (fr_sync == asfc_pkg::SY_HASH) begin
                    if (!star_hit) begin
                        rec.check_status = asfc_pkg::CK_MISSING;
                    end else if (star_tail == int'(asfc_pkg::HEX_DIGITS) && hex_ok) begin
                        rec.reported_crc = hex_acc;
                        rec.computed_crc = crc_star;
                        rec.check_status = (hex_acc == crc_star) ? asfc_pkg::CK_VALID :
                                                                   asfc_pkg::CK_INVALID;
                    end else begin
                        rec.check_status = asfc_pkg::CK_INVALID;
                    end
                end
                rec.frame_time_ns      = fr_time;
                rec.frame_time_present = fr_time_seen;
                rec.frame_bytes        = 16'(fr_count);
                rec.payload_bytes      = 16'(payload);
                rec.name_bytes         = 16'((name_len < payload) ? name_len : payload);
                close_frame();
            end
        end
    endtask

    // Random idle bursts, now and then followed by a calm stretch.
    task automatic pick_idle(inout int burst, inout int calm, output logic hold);
        hold = 1'b0;
        if (quiet) begin
            burst = 0;
        end else if (burst == 0 && calm == 0 && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 15);
        end
        if (burst > 0) begin
            hold = 1'b1;
            burst--;
            if (burst == 0 && $urandom_range(0, 3) == 0) begin
                calm = $urandom_range(20, 80);
            end
        end else if (calm > 0) begin
            calm--;
        end
    endtask

    // Input driver: predicts each accepted transaction, then presents the next pending one.
    asfc_pkg::t_item   taken_item;
    asfc_pkg::t_item   head_item;
    asfc_pkg::t_result predicted;
    int                send_burst = 0;
    int                send_calm  = 0;
    logic              send_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken_item.opcode       = s_axis_tuser[0];
                taken_item.time_present = s_axis_tuser[1];
                taken_item.data_byte    = s_axis_tdata[7:0];
                taken_item.time_ns      = s_axis_tdata[70:8];
                parse_sentence_byte(taken_item, predicted);
                expected_reports.insert(expected_reports.size(), predicted);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                pick_idle(send_burst, send_calm, send_hold);
                if (!send_hold && pending_items.size() > 0) begin
                    head_item = pending_items.pop_front();
                    s_axis_tdata  <= {1'b0, head_item.time_ns, head_item.data_byte};
                    s_axis_tuser  <= {head_item.time_present, head_item.opcode};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", field, want, seen);
            mismatches++;
        end
    endtask

    // Result monitor: every result transaction is matched against the oldest prediction.
    asfc_pkg::t_result want_report;
    int                recv_burst = 0;
    int                recv_calm  = 0;
    logic              recv_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transaction with status %0d arrived with none expected",
                           m_axis_tuser);
                    mismatches++;
                end else begin
                    want_report = expected_reports.pop_front();
                    check_field("status", 64'(want_report.status), 64'(m_axis_tuser));
                    check_field("sync_kind", 64'(want_report.sync_kind),
                                64'(m_axis_tdata[1:0]));
                    check_field("check_status", 64'(want_report.check_status),
                                64'(m_axis_tdata[3:2]));
                    check_field("reported_crc", 64'(want_report.reported_crc),
                                64'(m_axis_tdata[35:4]));
                    check_field("computed_crc", 64'(want_report.computed_crc),
                                64'(m_axis_tdata[67:36]));
                    check_field("frame_time_ns", 64'(want_report.frame_time_ns),
                                64'(m_axis_tdata[130:68]));
                    check_field("frame_time_present", 64'(want_report.frame_time_present),
                                64'(m_axis_tdata[131]));
                    check_field("frame_bytes", 64'(want_report.frame_bytes),
                                64'(m_axis_tdata[147:132]));
                    check_field("payload_bytes", 64'(want_report.payload_bytes),
                                64'(m_axis_tdata[163:148]));
                    check_field("name_bytes", 64'(want_report.name_bytes),
                                64'(m_axis_tdata[179:164]));
                end
            end
            pick_idle(recv_burst, recv_calm, recv_hold);
            m_axis_tready <= !recv_hold;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [62:0] random_time();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[62:0];
    endfunction

    task automatic queue_item(input logic op, input logic [7:0] b, input logic [62:0] t,
                              input logic tp);
        asfc_pkg::t_item it;
        it.opcode       = op;
        it.data_byte    = b;
        it.time_ns      = t;
        it.time_present = tp;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        queue_item(asfc_pkg::OP_PUSH, b, random_time(), 1'($urandom));
    endtask

    // Data and time of an end-of-stream transaction are ignored, so they are random.
    task automatic queue_eos();
        queue_item(asfc_pkg::OP_EOS, 8'($urandom), random_time(), 1'($urandom));
    endtask

    function automatic logic [7:0] pick_sync();
        case ($urandom_range(0, 4))
            3:       return asfc_pkg::CH_DOLLAR;
            4:       return asfc_pkg::CH_PERCENT;
            default: return asfc_pkg::CH_HASH;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return "0" + 8'(v);
        end
        return (($urandom_range(0, 1) == 1) ? "a" : "A") + 8'(v) - 8'd10;
    endfunction

    // Bytes of the sentence fields: mostly printable, with delimiters, stars and stray bytes.
    function automatic logic [7:0] field_char();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 45) return "0" + 8'($urandom_range(0, 9));
        if (r < 60) return "a" + 8'($urandom_range(0, 25));
        if (r < 72) return asfc_pkg::CH_COMMA;
        if (r < 77) return asfc_pkg::CH_SEMI;
        if (r < 82) return asfc_pkg::CH_SPACE;
        if (r < 85) return ".";
        if (r < 88) return asfc_pkg::CH_STAR;
        if (r < 91) return asfc_pkg::CH_CR;
        do begin
            b = 8'($urandom);
        end while (b == asfc_pkg::CH_LF);
        return b;
    endfunction

    // A whole sentence: name, fields, usually a checksum, a line ending of some shape.
    task automatic add_sentence();
        logic [7:0]  line[$];
        logic [7:0]  sync;
        logic [31:0] sum;
        int          n;
        int          flavor;
        int          digits;
        sync = pick_sync();
        n = $urandom_range(0, 6);
        repeat (n) line.insert(line.size(), 8'($urandom_range(65, 90)));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        repeat (n) line.insert(line.size(), field_char());
        if ($urandom_range(0, 9) < ((sync == asfc_pkg::CH_HASH) ? 9 : 3)) begin
            sum = '0;
            foreach (line[i]) sum = crc32_step(sum, line[i]);
            // Mostly a correct checksum; else a wrong value, a wrong digit count or a bad digit.
            flavor = $urandom_range(0, 9);
            if (flavor == 0) begin
                sum = sum ^ (32'd1 << $urandom_range(0, 31));
            end
            digits = (flavor == 1) ? $urandom_range(0, 10) : 8;
            line.insert(line.size(), asfc_pkg::CH_STAR);
            repeat (digits) begin
                line.insert(line.size(), hex_char(sum[31:28]));
                sum = {sum[27:0], 4'($urandom)};
            end
            if (flavor == 2 && digits > 0) begin
                line[line.size() - 1 - $urandom_range(0, digits - 1)] = "g";
            end
        end
        case ($urandom_range(0, 9))
            0: begin
            end
            8: begin
                line.insert(line.size(), asfc_pkg::CH_CR);
                line.insert(line.size(), asfc_pkg::CH_CR);
            end
            9: begin
                // A carriage return that turns out not to trail the line.
                line.insert(line.size(), asfc_pkg::CH_CR);
                line.insert(line.size(), "x");
                line.insert(line.size(), asfc_pkg::CH_CR);
            end
            default: begin
                line.insert(line.size(), asfc_pkg::CH_CR);
            end
        endcase
        queue_byte(sync);
        foreach (line[i]) queue_byte(line[i]);
        if ($urandom_range(0, 24) == 0) begin
            queue_eos();
        end else begin
            queue_byte(asfc_pkg::CH_LF);
        end
    endtask

    task automatic fill_random(input int count);
        int goal;
        int pick;
        int n;
        goal = pending_items.size() + count;
        while (pending_items.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                add_sentence();
            end else if (pick < 88) begin
                n = $urandom_range(1, 4);
                repeat (n) queue_byte(8'($urandom));
            end else if (pick < 93) begin
                queue_eos();
            end else begin
                // Broken sentence: a sync byte and arbitrary bytes, line feeds included.
                queue_byte(pick_sync());
                n = $urandom_range(0, 20);
                repeat (n) queue_byte(8'($urandom));
            end
        end
    endtask

    // Every input transaction gives exactly one result, so an empty prediction store means idle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    endtask

    task automatic write_frame_limit(input logic [15:0] limit);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_FRAME;
        pwdata  <= {16'd0, limit};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        frame_limit = limit;
    endtask

    task automatic run_phase(input logic [15:0] limit, input int count);
        write_frame_limit(limit);
        @(negedge i_clk);
        fill_random(count);
        wait_drained();
    endtask

    initial begin
        close_frame();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset limit. End of stream with nothing open, skipped bytes.
        queue_eos();
        queue_item(asfc_pkg::OP_PUSH, 8'h00, '0, 1'b0);
        queue_item(asfc_pkg::OP_PUSH, 8'hFF, '1, 1'b1);
        // A dollar frame with the largest timestamp and a name closed at once by a space.
        queue_item(asfc_pkg::OP_PUSH, asfc_pkg::CH_DOLLAR, '1, 1'b1);
        queue_byte(asfc_pkg::CH_SPACE);
        queue_byte(asfc_pkg::CH_LF);
        // The shortest percent frame, without a timestamp.
        queue_item(asfc_pkg::OP_PUSH, asfc_pkg::CH_PERCENT, '0, 1'b0);
        queue_byte(asfc_pkg::CH_LF);
        // Hash frame without a star: checksum missing; the trailing return is trimmed.
        queue_item(asfc_pkg::OP_PUSH, asfc_pkg::CH_HASH, '0, 1'b0);
        queue_byte("A");
        queue_byte(asfc_pkg::CH_CR);
        queue_byte(asfc_pkg::CH_LF);
        // Empty payload before the star has a checksum of zero.
        queue_byte(asfc_pkg::CH_HASH);
        queue_byte(asfc_pkg::CH_STAR);
        repeat (8) queue_byte("0");
        queue_byte(asfc_pkg::CH_CR);
        queue_byte(asfc_pkg::CH_LF);
        // End of stream inside a frame.
        queue_byte(asfc_pkg::CH_HASH);
        queue_eos();
        fill_random(190);
        wait_drained();

        run_phase(16'd12, 130);
        run_phase(16'd1, 80);
        run_phase(16'd0, 50);
        run_phase(16'd300, 160);
        run_phase(16'hFFFF, 130);

        // Last part without idling: a frame of exactly the limit, one a byte longer that
        // overflows at its line feed, then a random tail.
        quiet = 1'b1;
        write_frame_limit(16'd40);
        @(negedge i_clk);
        queue_byte(asfc_pkg::CH_HASH);
        repeat (38) queue_byte("a");
        queue_byte(asfc_pkg::CH_LF);
        queue_byte(asfc_pkg::CH_HASH);
        repeat (39) queue_byte("a");
        queue_byte(asfc_pkg::CH_LF);
        fill_random(60);
        wait_drained();

        // Room for a stray result to show up behind the two register stages.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
